>>> sv/sct_pkg.sv
// sct_pkg: shared constants, types and codes for the smoothstep curve table
// no dependencies
package sct_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int DATA_W     = 32;

  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_RELOAD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_IDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_START_POS = 2'd0,
    REG_START_VAL = 2'd1,
    REG_END_POS   = 2'd2,
    REG_END_VAL   = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SEG_RD,
    S_SEG_GET,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_BLEND,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_RM_RD,
    S_RM_WR,
    S_FND_RD,
    S_FND_CHK,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_RLD0,
    S_RLD1,
    S_DONE
  } state_t;

  // request to the shared multiplier/divider
  typedef struct packed {
    logic              mul_go;
    logic              div_go;
    logic signed [DATA_W:0] a;
    logic signed [DATA_W:0] b;
  } alu_req_t;

endpackage

>>> sv/sct_ram.sv
// sct_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module sct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sct_alu.sv
// sct_alu: shared arithmetic unit, one signed 33x33 multiply or a serial divide
// depends on sct_pkg
module sct_alu
  import sct_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  alu_req_t                 req,
  output logic                     busy,
  output logic signed [2*DATA_W+1:0] prod,
  output logic [2*DATA_W-1:0]      quot
);
  localparam int QW = 2 * DATA_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]     num_r, num_nxt;
  logic [QW-1:0]     rem_r, rem_nxt;
  logic [QW-1:0]     den_r, den_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic signed [2*DATA_W+1:0] prod_r;
  logic [QW-1:0]     trial;

  // multiply registered in one step
  always_ff @(posedge clk) begin
    if (req.mul_go) begin
      prod_r <= req.a * req.b;
    end
  end

  // restoring divide, one quotient bit per cycle, unsigned operands
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[QW-2:0], num_r[QW-1]};
    if (req.div_go) begin
      num_nxt  = QW'(req.a[DATA_W-1:0]) << FRAC_BITS;
      rem_nxt  = '0;
      den_nxt  = QW'(req.b[DATA_W-1:0]);
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= den_r) begin
        rem_nxt = trial - den_r;
        num_nxt = {num_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r | req.div_go;
  assign prod = prod_r;
  assign quot = num_r;
endmodule

>>> sv/sct_ctrl.sv
// sct_ctrl: command sequencer, walks the point table and drives the shared alu
// depends on sct_pkg, sct_ram, sct_alu
module sct_ctrl
  import sct_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] pos,
  input  logic signed [DATA_W-1:0] val,
  input  logic [IDX_W-1:0]         idx,
  input  logic [DATA_W-1:0]        start_position,
  input  logic [DATA_W-1:0]        start_value,
  input  logic [DATA_W-1:0]        end_position,
  input  logic [DATA_W-1:0]        end_value,
  output logic                     idle,
  output logic                     done,
  output logic signed [DATA_W-1:0] res_sample,
  output status_t                  res_status,
  output logic [CNT_W-1:0]         res_count
);
  localparam int PW = 2 * DATA_W;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic signed [DATA_W-1:0] p_r, v_r;
  logic boot_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] seg_r, seg_nxt;
  logic [CNT_W-1:0] dst_r, dst_nxt;
  logic signed [DATA_W-1:0] p0_r, p0_nxt, v0_r, v0_nxt, prev_r, prev_nxt;
  logic signed [DATA_W:0] wid_r, wid_nxt, dv_r, dv_nxt;
  logic signed [DATA_W:0] t_r, t_nxt, s_r, s_nxt;
  logic signed [DATA_W-1:0] smp_r, smp_nxt;
  status_t stat_r, stat_nxt;

  // table memories
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wpos, wval, rpos, rval;

  sct_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_pos (
    .clk, .we, .waddr, .wdata(wpos), .raddr, .rdata(rpos));
  sct_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_val (
    .clk, .we, .waddr, .wdata(wval), .raddr, .rdata(rval));

  // shared multiply / divide
  alu_req_t req;
  logic alu_busy;
  logic signed [2*DATA_W+1:0] prod;
  logic [PW-1:0] quot;

  sct_alu u_alu (.clk, .rst_n, .req, .busy(alu_busy), .prod, .quot);

  logic signed [DATA_W:0] rp;
  logic signed [2*DATA_W+1:0] pfix;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    seg_nxt   = seg_r;
    dst_nxt   = dst_r;
    p0_nxt    = p0_r;
    v0_nxt    = v0_r;
    prev_nxt  = prev_r;
    wid_nxt   = wid_r;
    dv_nxt    = dv_r;
    t_nxt     = t_r;
    s_nxt     = s_r;
    smp_nxt   = smp_r;
    stat_nxt  = stat_r;
    we        = 1'b0;
    waddr     = k_r[IDX_W-1:0];
    raddr     = k_r[IDX_W-1:0];
    wpos      = rpos;
    wval      = rval;
    req       = '0;
    rp        = {rpos[DATA_W-1], rpos};
    pfix      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          smp_nxt  = '0;
          stat_nxt = ST_OK;
          k_nxt    = '0;
          unique case (cmd)
            CMD_SAMPLE, CMD_ADD: state_nxt = S_SRCH_RD;
            CMD_UPDATE: begin
              if (CNT_W'(idx) >= cnt_r) begin
                stat_nxt  = ST_BAD_IDX;
                state_nxt = S_DONE;
              end else begin
                k_nxt     = CNT_W'(idx);
                state_nxt = S_RM_RD;
              end
            end
            CMD_RELOAD: state_nxt = S_RLD0;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // linear search: read entry k, compare with previous
      S_SRCH_RD: begin
        raddr     = k_r[IDX_W-1:0];
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (k_r != '0 && prev_r <= p_r && signed'(rpos) >= p_r) begin
          seg_nxt = k_r - CNT_W'(1);
          if (cmd_r == CMD_SAMPLE) begin
            wid_nxt   = rp - {p0_r[DATA_W-1], p0_r};
            state_nxt = S_SEG_RD;
            k_nxt     = k_r;
          end else if (cnt_r >= CNT_W'(MAX_POINTS)) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            k_nxt     = cnt_r;
            state_nxt = S_INS_RD;
          end
        end else if (k_r + CNT_W'(1) >= cnt_r) begin
          stat_nxt  = ST_OUTSIDE;
          state_nxt = S_DONE;
        end else begin
          prev_nxt  = rpos;
          p0_nxt    = rpos;
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_SRCH_RD;
        end
        if (k_r == '0) begin
          prev_nxt = rpos;
          p0_nxt   = rpos;
        end
      end
      // fetch both values of the segment: v1 at k, v0 at k-1
      S_SEG_RD: begin
        raddr     = seg_r[IDX_W-1:0];
        dv_nxt    = {rval[DATA_W-1], rval};
        state_nxt = S_SEG_GET;
      end
      S_SEG_GET: begin
        v0_nxt = rval;
        dv_nxt = dv_r - {rval[DATA_W-1], rval};
        if (wid_r <= 0) begin
          smp_nxt   = rval;
          state_nxt = S_DONE;
        end else begin
          req.div_go = 1'b1;
          req.a      = {1'b0, p_r - p0_r};
          req.b      = wid_r;
          state_nxt  = S_DIV;
        end
      end
      // divide finishes, clamp alpha, start t*t
      S_DIV: begin
        if (!alu_busy) begin
          if (quot > PW'(ONE_FX)) t_nxt = (DATA_W+1)'(ONE_FX);
          else t_nxt = (DATA_W+1)'(quot);
          req.mul_go = 1'b1;
          req.a      = (quot > PW'(ONE_FX)) ? (DATA_W+1)'(ONE_FX) : (DATA_W+1)'(quot);
          req.b      = req.a;
          state_nxt  = S_MUL1;
        end
      end
      // t2 * (3 - 2t)
      S_MUL1: begin
        req.mul_go = 1'b1;
        req.a      = (DATA_W+1)'(prod >>> FRAC_BITS);
        req.b      = (DATA_W+1)'(3 * ONE_FX) - (t_r <<< 1);
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        s_nxt      = (DATA_W+1)'(prod >>> FRAC_BITS);
        state_nxt  = S_MUL3;
      end
      // (v1 - v0) * s
      S_MUL3: begin
        req.mul_go = 1'b1;
        req.a      = dv_r;
        req.b      = s_r;
        state_nxt  = S_BLEND;
      end
      S_BLEND: begin
        if (prod >= 0) pfix = prod >>> FRAC_BITS;
        else pfix = -((-prod + (2*DATA_W+2)'(ONE_FX) - 1) >>> FRAC_BITS);
        smp_nxt   = v0_r + DATA_W'(pfix);
        state_nxt = S_DONE;
      end
      // add: shift entries up from count-1 down to seg+1
      S_INS_RD: begin
        if (k_r == seg_r + CNT_W'(1)) begin
          state_nxt = S_INS_PUT;
        end else begin
          raddr     = IDX_W'(k_r - CNT_W'(1));
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we        = 1'b1;
        waddr     = k_r[IDX_W-1:0];
        k_nxt     = k_r - CNT_W'(1);
        state_nxt = S_INS_RD;
      end
      S_INS_PUT: begin
        we        = 1'b1;
        waddr     = k_r[IDX_W-1:0];
        wpos      = p_r;
        wval      = v_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      // update: close the gap at idx
      S_RM_RD: begin
        if (k_r + CNT_W'(1) >= cnt_r) begin
          k_nxt     = '0;
          state_nxt = S_FND_RD;
        end else begin
          raddr     = IDX_W'(k_r + CNT_W'(1));
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR: begin
        we        = 1'b1;
        waddr     = k_r[IDX_W-1:0];
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_RM_RD;
      end
      // find first remaining entry with position above the new one
      S_FND_RD: begin
        if (k_r + CNT_W'(1) >= cnt_r) begin
          dst_nxt   = k_r;
          k_nxt     = k_r;
          state_nxt = S_PUT;
        end else begin
          raddr     = k_r[IDX_W-1:0];
          state_nxt = S_FND_CHK;
        end
      end
      S_FND_CHK: begin
        if (signed'(rpos) > p_r) begin
          dst_nxt   = k_r;
          k_nxt     = cnt_r - CNT_W'(1);
          state_nxt = S_MV_RD;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_FND_RD;
        end
      end
      S_MV_RD: begin
        if (k_r == dst_r) begin
          state_nxt = S_PUT;
        end else begin
          raddr     = IDX_W'(k_r - CNT_W'(1));
          state_nxt = S_MV_WR;
        end
      end
      S_MV_WR: begin
        we        = 1'b1;
        waddr     = k_r[IDX_W-1:0];
        k_nxt     = k_r - CNT_W'(1);
        state_nxt = S_MV_RD;
      end
      S_PUT: begin
        we        = 1'b1;
        waddr     = k_r[IDX_W-1:0];
        wpos      = p_r;
        wval      = v_r;
        state_nxt = S_DONE;
      end
      // reload endpoints; the pass after reset gives no result
      S_RLD0: begin
        we        = 1'b1;
        waddr     = '0;
        wpos      = start_position;
        wval      = start_value;
        state_nxt = S_RLD1;
      end
      S_RLD1: begin
        we        = 1'b1;
        waddr     = IDX_W'(1);
        wpos      = end_position;
        wval      = end_value;
        cnt_nxt   = CNT_W'(2);
        state_nxt = boot_r ? S_IDLE : S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RLD0;
      cnt_r   <= CNT_W'(2);
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_RLD1) begin
        boot_r <= 1'b0;
      end
    end
    if (start && state_r == S_IDLE) begin
      cmd_r <= cmd;
      p_r   <= pos;
      v_r   <= val;
    end
    k_r    <= k_nxt;
    seg_r  <= seg_nxt;
    dst_r  <= dst_nxt;
    p0_r   <= p0_nxt;
    v0_r   <= v0_nxt;
    prev_r <= prev_nxt;
    wid_r  <= wid_nxt;
    dv_r   <= dv_nxt;
    t_r    <= t_nxt;
    s_r    <= s_nxt;
    smp_r  <= smp_nxt;
    stat_r <= stat_nxt;
  end

  assign idle       = (state_r == S_IDLE);
  assign done       = (state_r == S_DONE);
  assign res_sample = smp_r;
  assign res_status = stat_r;
  assign res_count  = cnt_r;
endmodule

>>> sv/smoothstep_curve_table_core.sv
// smoothstep_curve_table_core: top level, config registers, handshakes, result register
// depends on sct_pkg, sct_ctrl
// One command at a time: a sample walks the table entry by entry, a read state and a
// check state per entry, then a serial divide and three multiplies on one shared unit;
// add and update shift entries one at a time through the table rams, a read state and
// a write state per moved entry; reload writes both endpoints. After reset the block
// writes the default endpoints before it accepts a command.
// The result sits in an output register; a new command is taken only once that result
// is leaving or has left, so a stalled result holds off the input.
module smoothstep_curve_table_core
  import sct_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_pos_in,
  input  logic signed [DATA_W-1:0] in_value_in,
  input  logic [IDX_W-1:0]         in_entry_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_sample_out,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);
  logic [DATA_W-1:0] start_pos_r, start_val_r, end_pos_r, end_val_r;
  logic idle, done, start;
  logic signed [DATA_W-1:0] res_sample;
  status_t res_status;
  logic [CNT_W-1:0] res_count;
  logic out_valid_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= '0;
      start_val_r <= '0;
      end_pos_r   <= ONE_FX;
      end_val_r   <= ONE_FX;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_POS: start_pos_r <= cfg_data;
        REG_START_VAL: start_val_r <= cfg_data;
        REG_END_POS:   end_pos_r   <= cfg_data;
        REG_END_VAL:   end_val_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept only when idle and the result slot is free or leaving
  assign in_stall = !idle || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;

  sct_ctrl u_ctrl (
    .clk, .rst_n, .start,
    .cmd(cmd_t'(in_cmd)), .pos(in_pos_in), .val(in_value_in), .idx(in_entry_index),
    .start_position(start_pos_r), .start_value(start_val_r),
    .end_position(end_pos_r), .end_value(end_val_r),
    .idle, .done, .res_sample, .res_status, .res_count);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (done) begin
      out_sample_out <= res_sample;
      out_status     <= res_status;
      out_count_out  <= res_count;
    end
  end
  assign out_valid = out_valid_r;
endmodule
